// File: design/cpd_pkg.sv
// Shared types and constants for the client packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package cpd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TDATA_W = 48;

  localparam logic [WORD_W-1:0] MAX_LEN_RESET = 16'd8192;

  localparam logic [BYTE_W-1:0] TYPE_INPUT  = 8'h49;  // 'I'
  localparam logic [BYTE_W-1:0] TYPE_RESIZE = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] TYPE_DETACH = 8'h44;  // 'D'

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RESIZE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DETACH  = 3'd0,
    KIND_RESIZE  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic {
    ERR_BAD_TYPE = 1'b0,
    ERR_TOO_LONG = 1'b1
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] columns;
    logic [WORD_W-1:0] rows;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    err_t              error_code;
  } result_t;

  localparam result_t RESULT_ZERO = '{
    kind: KIND_DETACH, columns: '0, rows: '0, payload_byte: '0,
    last: 1'b0, error_code: ERR_BAD_TYPE
  };

endpackage
`default_nettype wire

// File: design/cpd_in_reg.sv
// Input register stage: captures one byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
module cpd_in_reg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [cpd_pkg::BYTE_W-1:0] in_data,
  input  wire logic                      down_ready,
  output logic                           stage_valid,
  output logic [cpd_pkg::BYTE_W-1:0]     stage_data
);
  import cpd_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] data_r;

  // Held byte leaves whenever the output side can take its result slot.
  assign in_ready    = !valid_r || down_ready;
  assign valid_nxt   = in_ready ? in_valid : valid_r;
  assign stage_valid = valid_r;
  assign stage_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// File: design/cpd_parser.sv
// Packet parser: phase FSM, field assembly and result decode.
`timescale 1ns / 1ps
`default_nettype none
module cpd_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [cpd_pkg::WORD_W-1:0] cfg_wr_data,
  input  wire logic                       step,
  input  wire logic [cpd_pkg::BYTE_W-1:0] data_byte,
  output logic                            res_valid,
  output cpd_pkg::result_t                res
);
  import cpd_pkg::*;

  phase_t            phase_r,     phase_nxt;
  logic [1:0]        field_idx_r, field_idx_nxt;
  logic [WORD_W-1:0] column_r,    column_nxt;
  logic [BYTE_W-1:0] hi_byte_r,   hi_byte_nxt;
  logic [WORD_W-1:0] remain_r,    remain_nxt;
  logic [WORD_W-1:0] max_len_r;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] remain_dec;

  assign word       = {hi_byte_r, data_byte};
  assign remain_dec = remain_r - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      field_idx_r <= 2'd0;
      column_r    <= '0;
      hi_byte_r   <= '0;
      remain_r    <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      field_idx_r <= field_idx_nxt;
      column_r    <= column_nxt;
      hi_byte_r   <= hi_byte_nxt;
      remain_r    <= remain_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    field_idx_nxt = field_idx_r;
    column_nxt    = column_r;
    hi_byte_nxt   = hi_byte_r;
    remain_nxt    = remain_r;
    res_valid     = 1'b0;
    res           = RESULT_ZERO;
    unique case (phase_r)
      PH_IDLE: begin
        priority if (data_byte == TYPE_DETACH) begin
          res_valid = step;
          res.kind  = KIND_DETACH;
        end else if (data_byte == TYPE_RESIZE) begin
          phase_nxt     = PH_RESIZE;
          field_idx_nxt = 2'd0;
        end else if (data_byte == TYPE_INPUT) begin
          phase_nxt     = PH_LENGTH;
          field_idx_nxt = 2'd0;
        end else begin
          phase_nxt      = PH_ERROR;
          res_valid      = step;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_TYPE;
        end
      end
      PH_RESIZE: begin
        unique case (field_idx_r)
          2'd0, 2'd2: begin
            hi_byte_nxt   = data_byte;
            field_idx_nxt = field_idx_r + 2'd1;
          end
          2'd1: begin
            column_nxt    = word;
            field_idx_nxt = 2'd2;
          end
          default: begin
            phase_nxt     = PH_IDLE;
            field_idx_nxt = 2'd0;
            res_valid     = step;
            res.kind      = KIND_RESIZE;
            res.columns   = column_r;
            res.rows      = word;
          end
        endcase
      end
      PH_LENGTH: begin
        if (field_idx_r == 2'd0) begin
          hi_byte_nxt   = data_byte;
          field_idx_nxt = 2'd1;
        end else begin
          field_idx_nxt = 2'd0;
          priority if (word > max_len_r) begin
            phase_nxt      = PH_ERROR;
            res_valid      = step;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
          end else if (word == '0) begin
            phase_nxt = PH_IDLE;
            res_valid = step;
            res.kind  = KIND_EMPTY;
          end else begin
            remain_nxt = word;
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        remain_nxt       = remain_dec;
        res_valid        = step;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
        if (remain_dec == '0) begin
          phase_nxt = PH_IDLE;
          res.last  = 1'b1;
        end
      end
      // Terminal: drop everything until reset.
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/cpd_out_reg.sv
// Result register stage with downstream handshake.
`timescale 1ns / 1ps
`default_nettype none
module cpd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_valid,
  input  wire cpd_pkg::result_t res,
  output logic                  load_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cpd_pkg::result_t      out_res
);
  import cpd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign load_ready = !valid_r || out_ready;
  assign valid_nxt  = load_ready ? res_valid : valid_r;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// File: design/client_packet_deframer.sv
// Top level of the client packet deframer.
//
// Splits a byte stream of typed client packets. 'D' yields a detach result;
// 'R' plus four big-endian bytes (columns, rows) yields a resize result;
// 'I' plus a big-endian 16-bit length yields one result per payload byte,
// the final one flagged on out_tlast, or a single empty-input result for a
// zero length. An unknown type byte, or a length above the max length
// register (cfg_wr_data, reset 8192), yields one error result, after which
// every byte is dropped until reset. Throughput is one byte per clock, unless a
// stall on out_tready keeps the result register full: each byte passes an
// input register, a parser state update and a result register. A byte taken
// is held in the input register until the parser steps on it; its result, if
// any, is then loaded into the result register and presented on out_tvalid.
// Bytes that complete nothing (type bytes of 'R'/'I', header bytes, dropped
// bytes) produce no output transaction. Stalls on out_tready propagate
// combinationally to in_tready. Write cfg only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module client_packet_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [cpd_pkg::BYTE_W-1:0]  in_tdata,
  // out_tdata: [15:0] columns, [31:16] rows, [39:32] payload_byte,
  //            [40] error_code, [47:41] zero
  // out_tuser: [2:0] kind
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [cpd_pkg::TDATA_W-1:0]      out_tdata,
  output logic [cpd_pkg::KIND_W-1:0]       out_tuser,
  output logic                             out_tlast,
  input  wire logic                        cfg_wr_en,
  input  wire logic [cpd_pkg::WORD_W-1:0]  cfg_wr_data
);
  import cpd_pkg::*;

  logic              load_ready;
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_data;
  logic              step;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  cpd_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data     (in_tdata),
    .down_ready  (load_ready),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  // A held byte is processed in the cycle the result slot is free.
  assign step = stage_valid && load_ready;

  cpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .data_byte   (stage_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  cpd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .load_ready (load_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {7'd0, out_res.error_code, out_res.payload_byte,
                      out_res.rows, out_res.columns};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
`default_nettype wire
